### src/mtet_pkg.sv
// Package for the multi-touch event tracker: word types, event kinds, shared constants.
// No dependencies.
package mtet_pkg;

  localparam int unsigned CountW = 4;

  typedef enum logic [2:0] {
    KIND_PRESSED    = 3'd0,
    KIND_MOVED      = 3'd1,
    KIND_RELEASED   = 3'd2,
    KIND_NO_DATA    = 3'd3,
    KIND_BAD_COUNT  = 3'd4,
    KIND_FRAME_DONE = 3'd5
  } event_kind_e;

  typedef enum logic [1:0] {
    CMD_NO_DATA   = 2'd0,
    CMD_BAD_COUNT = 2'd1,
    CMD_FINISH    = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    BK_IDLE    = 2'd0,
    BK_CUR     = 2'd1,
    BK_PREV    = 2'd2,
    BK_DONE    = 2'd3
  } back_state_e;

  typedef struct packed {
    logic [7:0]  track_id;
    logic [15:0] pos_x;
    logic [15:0] pos_y;
    logic [15:0] contact_size;
  } point_t;

  typedef struct packed {
    logic        action;
    logic [7:0]  status_byte;
    logic [7:0]  track_id;
    logic [15:0] pos_x;
    logic [15:0] pos_y;
    logic [15:0] contact_size;
  } in_word_t;

  typedef struct packed {
    logic [2:0]  event_kind;
    logic [7:0]  event_id;
    logic [15:0] event_x;
    logic [15:0] event_y;
    logic [15:0] event_size;
    logic [2:0]  frame_points;
    logic        last_of_run;
  } out_word_t;

  typedef struct packed {
    cmd_e              cmd;
    logic [CountW-1:0] count;
  } cmd_t;

endpackage

### src/multi_touch_event_tracker.sv
// Top level of the multi-touch event tracker.
// Depends on mtet_pkg, mtet_front, mtet_queue, mtet_back.
//
// Usage: in_i carries one word per handshake, either a status byte
// (action 0) that opens a frame or one point record (action 1).
// out_o carries event words; last_of_run marks the final word caused
// by one input word.
// Flow: a no_data or bad_count word passes through the command queue
// into the output register. A word that completes a frame passes
// through the queue and starts the compare: current points one per
// cycle, previous points one per cycle (an empty phase still passes
// through its state), then frame_done; the walk holds while the
// output is stalled.
// Input is held off while a completed frame waits for or runs its
// compare, and while the command queue is full.
// Reset clears the open frame and the previous frame (zero points).
// A stalled receiver holds the output word and freezes the back end.
module multi_touch_event_tracker import mtet_pkg::*; #(
  parameter int unsigned MaxPoints = 5
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  in_word_t  in_i,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  output out_word_t out_o,
  output logic      out_valid_o,
  input  logic      out_ready_i
);
  cmd_t              fc, bc;
  logic              fc_v, fc_r, bc_v, bc_r, busy, wr_en;
  logic [CountW-1:0] wr_idx;
  point_t            wr_pt;

  mtet_front #(.MaxPoints(MaxPoints)) u_front (
    .clk_i, .rst_ni, .in_i, .in_valid_i, .in_ready_o,
    .cmd_o(fc), .cmd_valid_o(fc_v), .cmd_ready_i(fc_r), .busy_i(busy),
    .wr_en_o(wr_en), .wr_idx_o(wr_idx), .wr_pt_o(wr_pt)
  );

  mtet_queue u_queue (
    .clk_i, .rst_ni, .wr_i(fc), .wr_valid_i(fc_v), .wr_ready_o(fc_r),
    .rd_o(bc), .rd_valid_o(bc_v), .rd_ready_i(bc_r)
  );

  mtet_back #(.MaxPoints(MaxPoints)) u_back (
    .clk_i, .rst_ni, .cmd_i(bc), .cmd_valid_i(bc_v), .cmd_ready_o(bc_r),
    .busy_o(busy), .wr_en_i(wr_en), .wr_idx_i(wr_idx), .wr_pt_i(wr_pt),
    .out_o, .out_valid_o, .out_ready_i
  );
endmodule

### src/mtet_front.sv
// Front end: takes input words, tracks the open frame, stores point records.
// Depends on mtet_pkg; issues frame commands into the queue.
module mtet_front import mtet_pkg::*; #(
  parameter int unsigned MaxPoints = 5
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  in_word_t in_i,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  output cmd_t     cmd_o,
  output logic     cmd_valid_o,
  input  logic     cmd_ready_i,
  input  logic     busy_i,
  output logic     wr_en_o,
  output logic [CountW-1:0] wr_idx_o,
  output point_t   wr_pt_o
);
  logic              open_q, open_d;
  logic [CountW-1:0] exp_q, exp_d, rcv_q, rcv_d;
  logic [3:0]        cnt;
  logic              acc;

  assign cnt = in_i.status_byte[3:0];
  // Stall while a frame is being compared: cur_points is owned by the back end.
  assign in_ready_o = cmd_ready_i && !busy_i;
  assign acc = in_valid_i && in_ready_o;
  assign wr_pt_o = '{in_i.track_id, in_i.pos_x, in_i.pos_y, in_i.contact_size};
  assign wr_idx_o = rcv_q;

  always_comb begin
    open_d = open_q;
    exp_d = exp_q;
    rcv_d = rcv_q;
    cmd_valid_o = 1'b0;
    cmd_o = '{CMD_NO_DATA, exp_q};
    wr_en_o = 1'b0;
    if (acc) begin
      if (!in_i.action) begin
        open_d = 1'b0;
        rcv_d = '0;
        if (!in_i.status_byte[7]) begin
          cmd_valid_o = 1'b1;
        end else if (CountW'(cnt) > CountW'(MaxPoints)) begin
          cmd_valid_o = 1'b1;
          cmd_o.cmd = CMD_BAD_COUNT;
        end else begin
          exp_d = CountW'(cnt);
          if (cnt == 4'd0) begin
            cmd_valid_o = 1'b1;
            cmd_o = '{CMD_FINISH, '0};
          end else begin
            open_d = 1'b1;
          end
        end
      end else if (open_q && rcv_q < exp_q) begin
        wr_en_o = 1'b1;
        rcv_d = rcv_q + CountW'(1);
        if (rcv_d == exp_q) begin
          cmd_valid_o = 1'b1;
          cmd_o = '{CMD_FINISH, exp_q};
          open_d = 1'b0;
          rcv_d = '0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q <= 1'b0;
      exp_q <= '0;
      rcv_q <= '0;
    end else begin
      open_q <= open_d;
      exp_q <= exp_d;
      rcv_q <= rcv_d;
    end
  end
endmodule

### src/mtet_queue.sv
// Two-entry command queue between front and back end.
// Depends on mtet_pkg.
module mtet_queue import mtet_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  cmd_t wr_i,
  input  logic wr_valid_i,
  output logic wr_ready_o,
  output cmd_t rd_o,
  output logic rd_valid_o,
  input  logic rd_ready_i
);
  cmd_t       mem_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;
  logic       push, pop;

  assign wr_ready_o = cnt_q != 2'd2;
  assign rd_valid_o = cnt_q != 2'd0;
  assign rd_o = mem_q[rp_q];
  assign push = wr_valid_i && wr_ready_o;
  assign pop = rd_valid_o && rd_ready_i;

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wp_q] <= wr_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0;
      rp_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (push) wp_q <= !wp_q;
      if (pop) rp_q <= !rp_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule

### src/mtet_back.sv
// Back end: walks current and previous frames, emits events, commits the frame.
// Depends on mtet_pkg; holds point stores and the output register.
module mtet_back import mtet_pkg::*; #(
  parameter int unsigned MaxPoints = 5
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cmd_t      cmd_i,
  input  logic      cmd_valid_i,
  output logic      cmd_ready_o,
  output logic      busy_o,
  input  logic      wr_en_i,
  input  logic [CountW-1:0] wr_idx_i,
  input  point_t    wr_pt_i,
  output out_word_t out_o,
  output logic      out_valid_o,
  input  logic      out_ready_i
);
  localparam int unsigned IdxW = (MaxPoints > 1) ? $clog2(MaxPoints) : 1;

  point_t            cur_q  [MaxPoints];
  point_t            prev_q [MaxPoints];
  logic              pvld_q [MaxPoints];
  logic [CountW-1:0] pcnt_q, n_q, i_q;
  back_state_e       st_q, st_d;
  out_word_t         out_q;
  logic              ov_q;
  logic              can_emit;
  logic              emit;
  point_t            pa, pb, mp;
  logic              fnd_p, fnd_c;

  assign out_o = out_q;
  assign out_valid_o = ov_q;
  assign can_emit = !ov_q || out_ready_i;
  assign cmd_ready_o = (st_q == BK_IDLE) && can_emit;
  // A queued finish also owns cur_points until its walk is done.
  assign busy_o = (st_q != BK_IDLE) || (cmd_valid_i && cmd_i.cmd == CMD_FINISH);

  assign pa = cur_q[i_q[IdxW-1:0]];
  assign pb = pvld_q[i_q[IdxW-1:0]] ? prev_q[i_q[IdxW-1:0]] : '0;

  // First-match searches over the small stores.
  always_comb begin
    fnd_p = 1'b0;
    mp = '0;
    for (int k = MaxPoints - 1; k >= 0; k--) begin
      if (CountW'(k) < pcnt_q && (pvld_q[k] ? prev_q[k].track_id : 8'd0) == pa.track_id) begin
        fnd_p = 1'b1;
        mp = pvld_q[k] ? prev_q[k] : '0;
      end
    end
    fnd_c = 1'b0;
    for (int k = 0; k < MaxPoints; k++) begin
      if (CountW'(k) < n_q && cur_q[k].track_id == pb.track_id) fnd_c = 1'b1;
    end
  end

  always_comb begin
    st_d = st_q;
    emit = 1'b0;
    case (st_q)
      BK_IDLE: begin
        if (cmd_valid_i && can_emit) begin
          if (cmd_i.cmd == CMD_FINISH) st_d = BK_CUR;
          else emit = 1'b1;
        end
      end
      BK_CUR: if (can_emit) begin
        if (n_q == '0 || i_q + CountW'(1) >= n_q) st_d = BK_PREV;
        emit = (n_q != '0) && (!fnd_p || mp.pos_x != pa.pos_x || mp.pos_y != pa.pos_y);
      end
      BK_PREV: if (can_emit) begin
        if (pcnt_q == '0 || i_q + CountW'(1) >= pcnt_q) st_d = BK_DONE;
        emit = (pcnt_q != '0) && !fnd_c;
      end
      BK_DONE: if (can_emit) begin
        st_d = BK_IDLE;
        emit = 1'b1;
      end
      default: st_d = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i) cur_q[wr_idx_i[IdxW-1:0]] <= wr_pt_i;
    if (st_q == BK_DONE && can_emit) begin
      for (int k = 0; k < MaxPoints; k++) begin
        if (CountW'(k) < n_q) prev_q[k] <= cur_q[k];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= BK_IDLE;
      ov_q <= 1'b0;
      out_q <= '0;
      pcnt_q <= '0;
      n_q <= '0;
      i_q <= '0;
      for (int k = 0; k < MaxPoints; k++) pvld_q[k] <= 1'b0;
    end else begin
      st_q <= st_d;
      ov_q <= emit || (ov_q && !out_ready_i);
      case (st_q)
        BK_IDLE: begin
          i_q <= '0;
          if (cmd_valid_i && can_emit) begin
            n_q <= cmd_i.count;
            if (emit) begin
              out_q <= '{(cmd_i.cmd == CMD_NO_DATA) ? KIND_NO_DATA : KIND_BAD_COUNT,
                         8'd0, 16'd0, 16'd0, 16'd0, 3'd0, 1'b1};
            end
          end
        end
        BK_CUR: if (can_emit) begin
          if (n_q == '0 || i_q + CountW'(1) >= n_q) i_q <= '0;
          else i_q <= i_q + CountW'(1);
          if (emit) begin
            out_q <= '{fnd_p ? KIND_MOVED : KIND_PRESSED, pa.track_id, pa.pos_x, pa.pos_y,
                       pa.contact_size, 3'd0, 1'b0};
          end
        end
        BK_PREV: if (can_emit) begin
          i_q <= i_q + CountW'(1);
          if (emit) begin
            out_q <= '{KIND_RELEASED, pb.track_id, pb.pos_x, pb.pos_y, pb.contact_size,
                       3'd0, 1'b0};
          end
        end
        BK_DONE: if (can_emit) begin
          out_q <= '{KIND_FRAME_DONE, 8'd0, 16'd0, 16'd0, 16'd0, n_q[2:0], 1'b1};
          pcnt_q <= n_q;
          for (int k = 0; k < MaxPoints; k++) begin
            if (CountW'(k) < n_q) pvld_q[k] <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end
endmodule
